// ----- sv/program_status_register_write_top_defines.svh -----
// Assertion macros for the status register write block.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef PROGRAM_STATUS_REGISTER_WRITE_TOP_DEFINES_SVH
`define PROGRAM_STATUS_REGISTER_WRITE_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PSRW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PSRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/psrw_pkg.sv -----
// Shared types, constants and mode decode for the status register write block.
// No dependencies; every module file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package psrw_pkg;

  // Register file layout of the configuration port.
  localparam int PaddrW = 3;
  localparam logic [0:0] RegNonmaskableFiq = 1'b0;

  // Field masks of the current status register.
  localparam logic [31:0] MaskFlags  = 32'hF800_0000;
  localparam logic [31:0] MaskItHiJ  = 32'h0700_0000;
  localparam logic [31:0] MaskGe     = 32'h000F_0000;
  localparam logic [31:0] MaskItLo   = 32'h0000_FC00;
  localparam logic [31:0] MaskEndian = 32'h0000_0200;
  localparam logic [31:0] MaskAbort  = 32'h0000_0100;
  localparam logic [31:0] MaskIrq    = 32'h0000_0080;
  localparam logic [31:0] MaskFiq    = 32'h0000_0040;
  localparam logic [31:0] MaskThumb  = 32'h0000_0020;
  localparam logic [31:0] MaskMode   = 32'h0000_001F;

  // Field masks of a saved status register.
  localparam logic [31:0] SavedMaskFlags = 32'hFF00_0000;
  localparam logic [31:0] SavedMaskGe    = 32'h000F_0000;
  localparam logic [31:0] SavedMaskExt   = 32'h0000_FF00;
  localparam logic [31:0] SavedMaskCtl   = 32'h0000_00E0;

  localparam logic [31:0] StatusReset = 32'h0000_01D3;

  // Saved register bank.
  localparam int BankDepth = 7;
  localparam logic [2:0] BankNone = 3'd7;

  // Mode encodings.
  localparam logic [4:0] ModeUsr = 5'h10;
  localparam logic [4:0] ModeFiq = 5'h11;
  localparam logic [4:0] ModeIrq = 5'h12;
  localparam logic [4:0] ModeSvc = 5'h13;
  localparam logic [4:0] ModeMon = 5'h16;
  localparam logic [4:0] ModeAbt = 5'h17;
  localparam logic [4:0] ModeHyp = 5'h1A;
  localparam logic [4:0] ModeUnd = 5'h1B;
  localparam logic [4:0] ModeSys = 5'h1F;

  // Operation codes.
  localparam logic OpCurrent = 1'b0;
  localparam logic OpSaved   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] write_value;
    logic [3:0]  byte_mask;
    logic        exception_return;
    logic        irq_line_pending;
  } psrw_in_t;

  typedef struct packed {
    logic [31:0] status_after;
    logic [31:0] saved_after;
    logic        irq_now_pending;
    logic        fiq_enable_fault;
    logic        mode_changed;
    logic        unpredictable;
  } psrw_out_t;

  // State update handed from the merge logic to the state registers.
  typedef struct packed {
    logic [31:0] status_nxt;
    logic        bank_we;
    logic [2:0]  bank_idx;
    logic [31:0] bank_wdata;
  } psrw_upd_t;

  function automatic logic mode_valid(input logic [4:0] m);
    logic ok;
    ok = 1'b0;
    case (m)
      ModeUsr, ModeFiq, ModeIrq, ModeSvc, ModeMon,
      ModeAbt, ModeHyp, ModeUnd, ModeSys: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Index of the saved register that belongs to a mode, BankNone if none.
  function automatic logic [2:0] bank_of(input logic [4:0] m);
    logic [2:0] b;
    b = BankNone;
    case (m)
      ModeFiq: b = 3'd0;
      ModeIrq: b = 3'd1;
      ModeSvc: b = 3'd2;
      ModeMon: b = 3'd3;
      ModeAbt: b = 3'd4;
      ModeHyp: b = 3'd5;
      ModeUnd: b = 3'd6;
      default: b = BankNone;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- sv/psrw_apb.sv -----
// APB-style configuration register holding the non-maskable FIQ control bit.
// Depends on psrw_pkg for the address width and register index.
`timescale 1ns / 1ps
`default_nettype none

module psrw_apb
  import psrw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic                   nonmaskable_fiq
);

  logic nmfiq_r;
  logic nmfiq_nxt;
  logic sel_reg0;

  // Register 0 sits at byte address 0; the upper address bit selects it.
  assign sel_reg0 = (paddr[PaddrW-1] == RegNonmaskableFiq);
  assign pready   = 1'b1;

  // Write on the access phase of a write transfer.
  always_comb begin
    nmfiq_nxt = nmfiq_r;
    if (psel && penable && pwrite && sel_reg0) begin
      nmfiq_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmfiq_r <= 1'b0;
    end else begin
      nmfiq_r <= nmfiq_nxt;
    end
  end

  // Read back; unmapped addresses read as zero.
  assign prdata          = sel_reg0 ? {31'd0, nmfiq_r} : 32'd0;
  assign nonmaskable_fiq = nmfiq_r;

endmodule

`default_nettype wire

// ----- sv/psrw_merge.sv -----
// Masked field merge for one status register write beat, with event flags.
// Depends on psrw_pkg for field masks, mode decode and the beat structs.
`timescale 1ns / 1ps
`default_nettype none

module psrw_merge
  import psrw_pkg::*;
(
  input  wire psrw_in_t    in_beat,
  input  wire logic [31:0] status_old,
  input  wire logic        nonmaskable_fiq,
  input  wire logic [31:0] bank_rdata,
  output logic [2:0]       bank_ridx,
  output psrw_upd_t        upd,
  output psrw_out_t        result
);

  logic [31:0] val;
  logic [3:0]  bm;
  logic        exc;
  logic [31:0] wm_cur;
  logic [31:0] wm_sav;
  logic [31:0] status_new;
  logic [31:0] saved_new;
  logic [2:0]  bank_old;
  logic        irq_flag;
  logic        fiq_flag;
  logic        chg;
  logic        unp;
  logic        val_mode_ok;

  assign val         = in_beat.write_value;
  assign bm          = in_beat.byte_mask;
  assign exc         = in_beat.exception_return;
  assign val_mode_ok = mode_valid(val[4:0]);
  assign bank_old    = bank_of(status_old[4:0]);

  // Write mask and flags for the current register.
  always_comb begin
    wm_cur   = 32'd0;
    irq_flag = 1'b0;
    fiq_flag = 1'b0;
    chg      = 1'b0;
    if (bm[3]) begin
      wm_cur = wm_cur | MaskFlags;
      if (exc) begin
        wm_cur = wm_cur | MaskItHiJ;
      end
    end
    if (bm[2]) begin
      wm_cur = wm_cur | MaskGe;
    end
    if (bm[1]) begin
      wm_cur = wm_cur | MaskEndian | MaskAbort;
      if (exc) begin
        wm_cur = wm_cur | MaskItLo;
      end
    end
    if (bm[0]) begin
      wm_cur = wm_cur | MaskIrq;
      if (!val[7] && status_old[7] && in_beat.irq_line_pending) begin
        irq_flag = 1'b1;
      end
      // Clearing F while it is set is refused and flagged; F stays set.
      if (!nonmaskable_fiq || !val[6]) begin
        if (!val[6] && status_old[6]) begin
          fiq_flag = 1'b1;
        end else begin
          wm_cur = wm_cur | MaskFiq;
        end
      end
      if (exc) begin
        wm_cur = wm_cur | MaskThumb;
      end
      if (val_mode_ok) begin
        wm_cur = wm_cur | MaskMode;
        chg    = (val[4:0] != status_old[4:0]);
      end
    end
  end

  // Write mask for the saved register of the current mode.
  always_comb begin
    wm_sav = 32'd0;
    if (bm[3]) begin
      wm_sav = wm_sav | SavedMaskFlags;
    end
    if (bm[2]) begin
      wm_sav = wm_sav | SavedMaskGe;
    end
    if (bm[1]) begin
      wm_sav = wm_sav | SavedMaskExt;
    end
    if (bm[0]) begin
      wm_sav = wm_sav | SavedMaskCtl;
      if (val_mode_ok) begin
        wm_sav = wm_sav | MaskMode;
      end
    end
  end

  // Select the path by operation and build the new state.
  always_comb begin
    status_new = status_old;
    unp        = 1'b0;
    bank_ridx  = bank_old;
    if (in_beat.operation == OpCurrent) begin
      status_new = (status_old & ~wm_cur) | (val & wm_cur);
      unp        = bm[0] && !val_mode_ok;
      bank_ridx  = bank_of(status_new[4:0]);
    end else begin
      unp = (bank_old == BankNone) || (bm[0] && !val_mode_ok);
    end
  end

  assign saved_new = (bank_rdata & ~wm_sav) | (val & wm_sav);

  always_comb begin
    upd.status_nxt = status_new;
    upd.bank_we    = (in_beat.operation == OpSaved) && (bank_old != BankNone);
    upd.bank_idx   = bank_old;
    upd.bank_wdata = saved_new;
  end

  // Result beat; flags other than unpredictable apply only to the current register.
  always_comb begin
    result.status_after = status_new;
    if (bank_ridx == BankNone) begin
      result.saved_after = 32'd0;
    end else if (in_beat.operation == OpSaved) begin
      result.saved_after = saved_new;
    end else begin
      result.saved_after = bank_rdata;
    end
    result.irq_now_pending  = (in_beat.operation == OpCurrent) && irq_flag;
    result.fiq_enable_fault = (in_beat.operation == OpCurrent) && fiq_flag;
    result.mode_changed     = (in_beat.operation == OpCurrent) && chg;
    result.unpredictable    = unp;
  end

endmodule

`default_nettype wire

// ----- sv/program_status_register_write_top.sv -----
// Path: input register, then result register, to the result beat.
// Throughput: one write beat per cycle unless out_ready stalls; each beat commits to the status
// registers as it moves into the result register, so the next beat sees the updated state.
// Reset (synchronous, rst_n low): status register 0x000001D3, saved bank all zero,
// non-maskable FIQ bit off, both pipeline stages empty.
// Depends on psrw_pkg, psrw_apb, psrw_merge and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "program_status_register_write_top_defines.svh"

module program_status_register_write_top
  import psrw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire psrw_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output psrw_out_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic        nonmaskable_fiq;
  psrw_in_t    in_r;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  psrw_out_t   out_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] status_r;
  logic [31:0] bank_r [BankDepth];
  logic        commit;
  logic        in_take;
  logic [2:0]  bank_ridx;
  logic [31:0] bank_rdata;
  psrw_upd_t   upd;
  psrw_out_t   result;

  psrw_apb u_apb (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .nonmaskable_fiq (nonmaskable_fiq)
  );

  // Handshake: the input stage moves on whenever the result register is free or drains.
  assign commit        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || commit;
  assign in_take       = in_valid && in_ready;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !commit);
  assign out_valid_nxt = commit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (commit) begin
      out_r <= result;
    end
  end

  // Saved bank read port; modes without a saved register read zero.
  assign bank_rdata = (bank_ridx == BankNone) ? 32'd0 : bank_r[bank_ridx];

  psrw_merge u_merge (
    .in_beat         (in_r),
    .status_old      (status_r),
    .nonmaskable_fiq (nonmaskable_fiq),
    .bank_rdata      (bank_rdata),
    .bank_ridx       (bank_ridx),
    .upd             (upd),
    .result          (result)
  );

  // Architectural state, updated as a beat commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= StatusReset;
      for (int i = 0; i < BankDepth; i++) begin
        bank_r[i] <= 32'd0;
      end
    end else if (commit) begin
      status_r <= upd.status_nxt;
      if (upd.bank_we) begin
        bank_r[upd.bank_idx] <= upd.bank_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The current mode is always a legal mode once out of reset.
  `PSRW_ASSERT_IMPL(a_mode_legal, 1'b1, mode_valid(status_r[4:0]), "illegal current mode")
  // State changes only when a beat commits.
  `PSRW_ASSERT_NEXT(a_state_hold, !commit, $stable(status_r), "status changed without commit")
  // A refused FIQ enable leaves F set in the reported status.
  `PSRW_ASSERT_IMPL(a_fiq_stays, out_valid_r && out_r.fiq_enable_fault,
                    out_r.status_after[6], "F cleared on refused FIQ enable")
  // A saved write never reports a mode change.
  `PSRW_ASSERT_NEXT(a_saved_no_chg, commit && (in_r.operation == OpSaved),
                    !out_r.mode_changed && !out_r.irq_now_pending, "flag on saved write")

endmodule

`default_nettype wire
